>>> design/tls_pkg.sv
// shared types, register codes and reset values for the threshold laplacian sharpener
`default_nettype none

package tls_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE     = 3'd4;

  localparam logic [11:0] RST_FRAME_WIDTH    = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT   = 12'd480;
  localparam logic [2:0]  RST_SHIFT_LEVEL    = 3'd4;
  localparam logic [10:0] RST_EDGE_THRESHOLD = 11'd50;
  localparam logic        RST_COLOR_MODE     = 1'b0;

  typedef logic [7:0] pix_t;

  typedef struct packed {
    pix_t a;
    pix_t b;
    pix_t c;
  } rgb_t;

  typedef struct packed {
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
    logic       flush_item;
  } in_item_t;

  typedef struct packed {
    logic [7:0] res_a;
    logic [7:0] res_b;
    logic [7:0] res_c;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_req_t;

  // filter settings handed to each channel unit
  typedef struct packed {
    logic [10:0] edge_threshold;
    logic [2:0]  shift_level;
  } sharp_cfg_t;

endpackage

`default_nettype wire

>>> design/tls_stream_if.sv
// valid/ready channel carrying one request payload
`default_nettype none

interface tls_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/tls_line_mem.sv
// two line stores sharing one address, registered read
`default_nettype none

module tls_line_mem #(
  parameter int MAX_WIDTH = tls_pkg::DEF_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire tls_pkg::rgb_t wr_upper,
  input  wire tls_pkg::rgb_t wr_lower,
  output tls_pkg::rgb_t      rd_upper,
  output tls_pkg::rgb_t      rd_lower
);
  import tls_pkg::*;

  rgb_t upper_mem_r [MAX_WIDTH];
  rgb_t lower_mem_r [MAX_WIDTH];
  rgb_t rd_upper_r;
  rgb_t rd_lower_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem_r[wr_addr] <= wr_upper;
      lower_mem_r[wr_addr] <= wr_lower;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper_r <= upper_mem_r[rd_addr];
      rd_lower_r <= lower_mem_r[rd_addr];
    end
  end

  assign rd_upper = rd_upper_r;
  assign rd_lower = rd_lower_r;

endmodule

`default_nettype wire

>>> design/tls_chan.sv
// thresholded laplacian sharpening of one 8-bit channel
`default_nettype none

module tls_chan (
  input  wire logic [7:0][7:0]    nbr,
  input  wire tls_pkg::pix_t      centre,
  input  wire tls_pkg::sharp_cfg_t cfg,
  output tls_pkg::pix_t           res
);
  import tls_pkg::*;

  logic [10:0]        nsum;
  logic signed [11:0] esum;
  logic [11:0]        mag_full;
  logic [10:0]        mag;
  logic signed [11:0] q;
  logic signed [12:0] v;
  pix_t               clamped;

  always_comb begin
    nsum = '0;
    for (int k = 0; k < 8; k++) begin
      nsum = nsum + 11'(nbr[k]);
    end
  end

  // neighbours minus eight times the centre
  assign esum     = signed'({1'b0, nsum}) - signed'({1'b0, centre, 3'b000});
  assign mag_full = esum[11] ? 12'(-esum) : 12'(esum);
  assign mag      = mag_full[10:0];
  assign q        = esum >>> cfg.shift_level;
  assign v        = signed'({5'b0, centre}) - signed'({q[11], q});

  always_comb begin
    if (v[12]) begin
      clamped = '0;
    end else if (v > 13'sd255) begin
      clamped = 8'hFF;
    end else begin
      clamped = v[7:0];
    end
  end

  assign res = (mag > cfg.edge_threshold) ? clamped : centre;

endmodule

`default_nettype wire

>>> design/threshold_laplacian_sharpen_unit.sv
// top level: raster-order 3x3 thresholded laplacian sharpener with two line stores
// latency: a pixel reaches its neighbourhood one row plus one pixel later in the stream;
//   the result of the item that completes it passes stage one, then the result register
// throughput: one request per cycle if not stalled, set by one shared line-store read port
// reset: counters, window and handshake state clear, registers take their defaults;
//   line stores are not cleared and no clearing pass runs
`default_nettype none

module threshold_laplacian_sharpen_unit #(
  parameter int MAX_WIDTH  = tls_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tls_pkg::DEF_MAX_HEIGHT
) (
  input wire logic   clk,
  input wire logic   rst_n,
  tls_stream_if.sink   in_if,
  tls_stream_if.source out_if,
  tls_stream_if.sink   cfg_if
);
  import tls_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int BW = $clog2(MAX_WIDTH + 3);
  localparam int GW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
  localparam int GH = (RW > CFG_DATA_W) ? RW : CFG_DATA_W;

  typedef struct packed {
    logic flush;
    logic emit;
    logic filt;
    logic fend;
    logic sel_upper;
    logic byp;
  } s1_ctrl_t;

  // configuration registers
  logic [11:0] frame_width_r;
  logic [11:0] frame_height_r;
  logic [2:0]  shift_level_r;
  logic [10:0] edge_threshold_r;
  logic        color_mode_r;

  // position and backlog counters
  logic [CW-1:0] in_col_r, out_col_r;
  logic [RW-1:0] in_row_r, out_row_r;
  logic [BW-1:0] backlog_r;
  logic [CW-1:0] in_col_nxt, out_col_nxt;
  logic [RW-1:0] in_row_nxt, out_row_nxt;
  logic [BW-1:0] backlog_nxt;

  // stage one
  logic      s1_valid_r;
  s1_ctrl_t  s1_ctrl_r, s1_ctrl_nxt;
  logic [AW-1:0] s1_addr_r;
  rgb_t      s1_pix_r;
  rgb_t      s1_byp_up_r, s1_byp_lo_r;

  // window: middle and right columns, rows top to bottom
  rgb_t win_mid_r [3];
  rgb_t win_rgt_r [3];

  // result register
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  logic [GW-1:0] fw_ext;
  logic [GH-1:0] fh_ext;
  logic [CW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic [BW-1:0] w_plus1, w_plus2;

  logic [CW-1:0] in_col_w, out_col_w, in_col_inc, out_col_inc, rd_col;
  logic [RW-1:0] in_row_w, out_row_w, in_row_inc, out_row_inc;
  logic [BW-1:0] bl_inc, bl_sat, bl_clip;
  logic          item_emit, border, fend;
  logic [AW-1:0] rd_addr;

  logic in_acc, s1_go, mem_wr, byp_hit;
  rgb_t in_pix, mem_rd_up, mem_rd_lo, up_eff, lo_eff, centre;
  pix_t [2:0] sharp;
  sharp_cfg_t scfg;

  assign fw_ext = GW'(frame_width_r);
  assign fh_ext = GH'(frame_height_r);
  assign eff_w  = (fw_ext < GW'(3)) ? CW'(3) :
                  (fw_ext > GW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(fw_ext);
  assign eff_h  = (fh_ext < GH'(3)) ? RW'(3) :
                  (fh_ext > GH'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(fh_ext);
  assign w_plus1 = BW'(eff_w) + BW'(1);
  assign w_plus2 = BW'(eff_w) + BW'(2);

  // handshakes
  assign s1_go       = s1_valid_r && (!s1_ctrl_r.emit || !out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_go;
  assign in_acc      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign in_pix = {in_if.payload.chan_a, in_if.payload.chan_b, in_if.payload.chan_c};

  // request-time bookkeeping: positions, backlog and what the item will emit
  always_comb begin
    in_col_w  = (in_col_r  >= eff_w) ? '0 : in_col_r;
    in_row_w  = (in_row_r  >= eff_h) ? '0 : in_row_r;
    out_col_w = (out_col_r >= eff_w) ? '0 : out_col_r;
    out_row_w = (out_row_r >= eff_h) ? '0 : out_row_r;

    in_col_inc  = in_col_w + CW'(1);
    in_row_inc  = in_row_w + RW'(1);
    out_col_inc = out_col_w + CW'(1);
    out_row_inc = out_row_w + RW'(1);

    bl_inc  = backlog_r + BW'(1);
    bl_sat  = (bl_inc > w_plus2) ? w_plus2 : bl_inc;
    bl_clip = (backlog_r > w_plus1) ? w_plus1 : backlog_r;

    in_col_nxt = in_col_w;
    in_row_nxt = in_row_w;
    if (in_if.payload.flush_item) begin
      item_emit   = (bl_clip != '0);
      backlog_nxt = item_emit ? (bl_clip - BW'(1)) : bl_clip;
      rd_col      = out_col_w;
    end else begin
      item_emit   = (bl_sat > w_plus1);
      backlog_nxt = item_emit ? (bl_sat - BW'(1)) : bl_sat;
      rd_col      = in_col_w;
      if (in_col_inc >= eff_w) begin
        in_col_nxt = '0;
        in_row_nxt = (in_row_inc >= eff_h) ? '0 : in_row_inc;
      end else begin
        in_col_nxt = in_col_inc;
      end
    end

    out_col_nxt = out_col_w;
    out_row_nxt = out_row_w;
    if (item_emit) begin
      if (out_col_inc >= eff_w) begin
        out_col_nxt = '0;
        out_row_nxt = (out_row_inc >= eff_h) ? '0 : out_row_inc;
      end else begin
        out_col_nxt = out_col_inc;
      end
    end

    border = (out_row_w == '0) || (out_row_w >= eff_h - RW'(1)) ||
             (out_col_w == '0) || (out_col_w >= eff_w - CW'(1));
    fend   = (out_row_w == eff_h - RW'(1)) && (out_col_w == eff_w - CW'(1));
  end

  assign rd_addr = rd_col[AW-1:0];

  // stage one writes the column this cycle: forward its new contents
  assign mem_wr  = s1_go && !s1_ctrl_r.flush;
  assign byp_hit = mem_wr && (s1_addr_r == rd_addr);

  always_comb begin
    s1_ctrl_nxt.flush     = in_if.payload.flush_item;
    s1_ctrl_nxt.emit      = item_emit;
    s1_ctrl_nxt.filt      = !in_if.payload.flush_item && !border;
    s1_ctrl_nxt.fend      = fend;
    s1_ctrl_nxt.sel_upper = (bl_clip == w_plus1);
    s1_ctrl_nxt.byp       = byp_hit;
  end

  tls_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_addr  (rd_addr),
    .wr_en    (mem_wr),
    .wr_addr  (s1_addr_r),
    .wr_upper (lo_eff),
    .wr_lower (s1_pix_r),
    .rd_upper (mem_rd_up),
    .rd_lower (mem_rd_lo)
  );

  assign up_eff = s1_ctrl_r.byp ? s1_byp_up_r : mem_rd_up;
  assign lo_eff = s1_ctrl_r.byp ? s1_byp_lo_r : mem_rd_lo;
  assign centre = win_rgt_r[1];

  assign scfg.edge_threshold = edge_threshold_r;
  assign scfg.shift_level    = shift_level_r;

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    localparam int LSB = (2 - ch) * 8;
    logic [7:0][7:0] nbr;

    assign nbr[0] = win_mid_r[0][LSB +: 8];
    assign nbr[1] = win_rgt_r[0][LSB +: 8];
    assign nbr[2] = up_eff[LSB +: 8];
    assign nbr[3] = win_mid_r[1][LSB +: 8];
    assign nbr[4] = lo_eff[LSB +: 8];
    assign nbr[5] = win_mid_r[2][LSB +: 8];
    assign nbr[6] = win_rgt_r[2][LSB +: 8];
    assign nbr[7] = s1_pix_r[LSB +: 8];

    tls_chan u_chan (
      .nbr    (nbr),
      .centre (centre[LSB +: 8]),
      .cfg    (scfg),
      .res    (sharp[ch])
    );
  end

  always_comb begin
    if (s1_ctrl_r.flush) begin
      out_item_nxt.res_a = s1_ctrl_r.sel_upper ? up_eff.a : lo_eff.a;
      out_item_nxt.res_b = s1_ctrl_r.sel_upper ? up_eff.b : lo_eff.b;
      out_item_nxt.res_c = s1_ctrl_r.sel_upper ? up_eff.c : lo_eff.c;
    end else begin
      out_item_nxt.res_a = s1_ctrl_r.filt ? sharp[0] : centre.a;
      out_item_nxt.res_b = (s1_ctrl_r.filt && color_mode_r) ? sharp[1] : centre.b;
      out_item_nxt.res_c = (s1_ctrl_r.filt && color_mode_r) ? sharp[2] : centre.c;
    end
    out_item_nxt.frame_end = s1_ctrl_r.fend;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= RST_FRAME_WIDTH;
      frame_height_r   <= RST_FRAME_HEIGHT;
      shift_level_r    <= RST_SHIFT_LEVEL;
      edge_threshold_r <= RST_EDGE_THRESHOLD;
      color_mode_r     <= RST_COLOR_MODE;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.payload.index)
        REG_FRAME_WIDTH:    frame_width_r    <= cfg_if.payload.data;
        REG_FRAME_HEIGHT:   frame_height_r   <= cfg_if.payload.data;
        REG_SHIFT_LEVEL:    shift_level_r    <= cfg_if.payload.data[2:0];
        REG_EDGE_THRESHOLD: edge_threshold_r <= cfg_if.payload.data[10:0];
        REG_COLOR_MODE:     color_mode_r     <= cfg_if.payload.data[0];
        default: ;
      endcase
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      backlog_r <= '0;
    end else if (in_acc) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      backlog_r <= backlog_nxt;
    end
  end

  // stage one control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctrl_r   <= s1_ctrl_nxt;
      s1_addr_r   <= rd_addr;
      s1_pix_r    <= in_pix;
      s1_byp_up_r <= lo_eff;
      s1_byp_lo_r <= s1_pix_r;
    end
  end

  // window shift on each pixel leaving stage one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_mid_r <= '{default: '0};
      win_rgt_r <= '{default: '0};
    end else if (mem_wr) begin
      win_mid_r    <= win_rgt_r;
      win_rgt_r[0] <= up_eff;
      win_rgt_r[1] <= lo_eff;
      win_rgt_r[2] <= s1_pix_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_ctrl_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_ctrl_r.emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_item_r;

  // two line-store writes on back-to-back cycles always hit different columns
  a_wr_cols_differ: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr && $past(mem_wr) |-> s1_addr_r != $past(s1_addr_r))
    else $error("consecutive line store writes to one column");

  // the input side only stalls behind an emitting item blocked by a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> s1_valid_r && s1_ctrl_r.emit && out_valid_r && !out_if.ready)
    else $error("input stalled without a blocked result");

  // a new result only ever comes from an emitting stage-one item
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_ctrl_r.emit))
    else $error("result appeared without an emitting item");

endmodule

`default_nettype wire

>>> bench/threshold_laplacian_sharpen_unit_test.sv
// self-checking bench for the thresholded laplacian sharpener: framed pixel streams against a tracker
`timescale 1ns / 100ps

module threshold_laplacian_sharpen_unit_test;
  import tls_pkg::*;

  typedef enum int {PAT_NOISE, PAT_SMOOTH, PAT_BINARY, PAT_SPIKES} pattern_e;

  // mirrors the sharpener: line stores, window, positions and owed results
  class sharpen_tracker;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [2:0]  shift_reg;
    logic [10:0] thresh_reg;
    logic        color_reg;
    logic [23:0] upper_row [DEF_MAX_WIDTH];
    logic [23:0] lower_row [DEF_MAX_WIDTH];
    logic [23:0] win [9];
    int unsigned in_col, in_row, out_col, out_row, owed;
    out_item_t   expected_px [$];
    int unsigned errors;

    function new();
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      shift_reg  = RST_SHIFT_LEVEL;
      thresh_reg = RST_EDGE_THRESHOLD;
      color_reg  = RST_COLOR_MODE;
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      owed = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:    width_reg  = data;
        REG_FRAME_HEIGHT:   height_reg = data;
        REG_SHIFT_LEVEL:    shift_reg  = data[2:0];
        REG_EDGE_THRESHOLD: thresh_reg = data[10:0];
        REG_COLOR_MODE:     color_reg  = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [11:0] v, int unsigned lim);
      if (v < 3) return 3;
      if (v > lim) return lim;
      return 32'(v);
    endfunction

    function int unsigned eff_width();
      return clamp_dim(width_reg, DEF_MAX_WIDTH);
    endfunction

    function int unsigned eff_height();
      return clamp_dim(height_reg, DEF_MAX_HEIGHT);
    endfunction

    function pix_t sharpen_chan(int unsigned sh);
      int c, sum, mag, q, v, k;
      c = int'((win[4] >> sh) & 24'hFF);
      sum = 0;
      for (k = 0; k < 9; k++) begin
        if (k != 4) sum += int'((win[k] >> sh) & 24'hFF) - c;
      end
      mag = (sum < 0) ? -sum : sum;
      if (mag <= int'(thresh_reg)) return pix_t'(c);
      // floor shift, negative sums round towards minus infinity
      q = sum >>> shift_reg;
      v = c - q;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return pix_t'(v);
    endfunction

    function void emit(logic [23:0] center, bit windowed);
      out_item_t   px;
      int unsigned w, h;
      bit          border;
      w = eff_width();
      h = eff_height();
      px.res_a = center[23:16];
      px.res_b = center[15:8];
      px.res_c = center[7:0];
      border = (out_row == 0) || (out_row >= h - 1) || (out_col == 0) || (out_col >= w - 1);
      if (windowed && !border) begin
        px.res_a = sharpen_chan(16);
        if (color_reg) begin
          px.res_b = sharpen_chan(8);
          px.res_c = sharpen_chan(0);
        end
      end
      px.frame_end = (out_row == h - 1) && (out_col == w - 1);
      expected_px.push_back(px);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
        if (out_row >= h) out_row = 0;
      end
    endfunction

    function void take_pixel(in_item_t it);
      int unsigned w, h, row;
      logic [23:0] px;
      w = eff_width();
      h = eff_height();
      if (in_col >= w) in_col = 0;
      if (in_row >= h) in_row = 0;
      if (out_col >= w) out_col = 0;
      if (out_row >= h) out_row = 0;
      if (it.flush_item) begin
        if (owed > w + 1) owed = w + 1;
        if (owed == 0) return;
        // the oldest owed pixel sits in the upper store only when a full row plus one is owed
        px = (owed == w + 1) ? upper_row[out_col] : lower_row[out_col];
        owed--;
        emit(px, 1'b0);
        return;
      end
      px = {it.chan_a, it.chan_b, it.chan_c};
      for (row = 0; row < 3; row++) begin
        win[row * 3]     = win[row * 3 + 1];
        win[row * 3 + 1] = win[row * 3 + 2];
      end
      win[2] = upper_row[in_col];
      win[5] = lower_row[in_col];
      win[8] = px;
      upper_row[in_col] = lower_row[in_col];
      lower_row[in_col] = px;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
      owed++;
      if (owed > w + 2) owed = w + 2;
      if (owed > w + 1) begin
        owed--;
        emit(win[4], 1'b1);
      end
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (expected_px.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %h", $time, got);
        return;
      end
      want = expected_px.pop_front();
      if (got.res_a !== want.res_a) report("res_a", want.res_a, got.res_a);
      if (got.res_b !== want.res_b) report("res_b", want.res_b, got.res_b);
      if (got.res_c !== want.res_c) report("res_c", want.res_c, got.res_c);
      if (got.frame_end !== want.frame_end)
        report("frame_end", 8'(want.frame_end), 8'(got.frame_end));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tls_stream_if #(.payload_t(in_item_t))  in_ch ();
  tls_stream_if #(.payload_t(out_item_t)) out_ch ();
  tls_stream_if #(.payload_t(cfg_req_t))  cfg_ch ();

  threshold_laplacian_sharpen_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  sharpen_tracker tracker;
  int unsigned    fed_items = 0;
  bit             in_busy   = 1'b0;
  int unsigned    in_left   = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic push_item(in_item_t item);
    int unsigned gap;
    if (in_left == 0) begin
      in_busy = ($urandom_range(0, 3) != 0);
      in_left = $urandom_range(10, 60);
    end
    in_left--;
    gap = in_busy ? $urandom_range(0, 17) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.payload = item;
    in_ch.valid   = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    fed_items++;
    tracker.take_pixel(item);
  endtask

  task automatic push_pixel(pix_t a, pix_t b, pix_t c);
    in_item_t item;
    item.chan_a = a;
    item.chan_b = b;
    item.chan_c = c;
    item.flush_item = 1'b0;
    push_item(item);
  endtask

  task automatic push_flush();
    in_item_t item;
    item.chan_a = pix_t'($urandom_range(0, 255));
    item.chan_b = pix_t'($urandom_range(0, 255));
    item.chan_c = pix_t'($urandom_range(0, 255));
    item.flush_item = 1'b1;
    push_item(item);
  endtask

  task automatic drain_backlog();
    while (tracker.owed != 0) push_flush();
  endtask

  // idle the input and let every expected result and any late request work out
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.expected_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_req_t req;
    req.index = idx;
    req.data  = value;
    @(negedge clk);
    cfg_ch.payload = req;
    cfg_ch.valid   = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.write_reg(idx, value);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic pix_t draw_sample(pattern_e pat, pix_t base);
    int v;
    case (pat)
      PAT_NOISE:  return pix_t'($urandom_range(0, 255));
      PAT_SMOOTH: begin
        v = int'(base) + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return pix_t'(v);
      end
      PAT_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default:    return ($urandom_range(0, 7) == 0) ? pix_t'($urandom_range(0, 255)) : base;
    endcase
  endfunction

  task automatic run_frames(int unsigned frames);
    int unsigned w, h, f, r, c;
    pattern_e    pat;
    pix_t        base_a, base_b, base_c;
    w = tracker.eff_width();
    h = tracker.eff_height();
    for (f = 0; f < frames; f++) begin
      pat = pattern_e'($urandom_range(0, 3));
      base_a = pix_t'($urandom_range(0, 255));
      base_b = pix_t'($urandom_range(0, 255));
      base_c = pix_t'($urandom_range(0, 255));
      for (r = 0; r < h; r++) begin
        for (c = 0; c < w; c++) begin
          // a stray flush mid-frame lets at most one pixel out unsharpened
          if ($urandom_range(0, 40) == 0) push_flush();
          push_pixel(draw_sample(pat, base_a), draw_sample(pat, base_b),
                     draw_sample(pat, base_c));
        end
      end
      if ($urandom_range(0, 3) == 0) drain_backlog();
    end
  endtask

  task automatic run_directed();
    int unsigned i;
    // nothing owed yet, so no result
    push_flush();
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'hAA, 8'h55, 8'h0F);
    push_pixel(8'h55, 8'hAA, 8'hF0);
    push_pixel(8'h01, 8'h80, 8'hFE);
    drain_backlog();
    push_flush();
    settle();
    write_reg(REG_FRAME_WIDTH, 12'd3);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    write_reg(REG_SHIFT_LEVEL, 12'd3);
    write_reg(REG_EDGE_THRESHOLD, 12'd0);
    write_reg(REG_COLOR_MODE, 12'd1);
    // bright centre clamps high, dark centre clamps low, flat blue sits on the threshold
    for (i = 0; i < 9; i++) begin
      if (i == 4) push_pixel(8'hFF, 8'h00, 8'h80);
      else push_pixel(8'h00, 8'hFF, 8'h80);
    end
    drain_backlog();
  endtask

  task automatic run_random_phase();
    logic [11:0] wv, hv, tv;
    settle();
    case ($urandom_range(0, 9))
      0:       wv = 12'($urandom_range(0, 2));
      1:       wv = 12'd3;
      default: wv = 12'($urandom_range(4, 14));
    endcase
    case ($urandom_range(0, 9))
      0:       hv = 12'($urandom_range(0, 2));
      1:       hv = 12'd3;
      default: hv = 12'($urandom_range(4, 9));
    endcase
    case ($urandom_range(0, 5))
      0:       tv = 12'd0;
      1:       tv = 12'd2040;
      2:       tv = 12'd2047;
      3:       tv = 12'($urandom_range(0, 2047));
      default: tv = 12'($urandom_range(0, 400));
    endcase
    write_reg(REG_FRAME_WIDTH, wv);
    write_reg(REG_FRAME_HEIGHT, hv);
    write_reg(REG_SHIFT_LEVEL, 12'($urandom_range(0, 7)));
    write_reg(REG_EDGE_THRESHOLD, tv);
    write_reg(REG_COLOR_MODE, 12'($urandom_range(0, 1)));
    run_frames($urandom_range(1, 3));
    drain_backlog();
    if ($urandom_range(0, 1) != 0) push_flush();
  endtask

  // widest line: part of one row at the clamped width, then drained through the line stores
  task automatic run_wide_phase();
    int unsigned i;
    settle();
    write_reg(REG_FRAME_WIDTH, ($urandom_range(0, 1) != 0) ? 12'd2048 : 12'd4095);
    write_reg(REG_FRAME_HEIGHT, 12'd4095);
    write_reg(REG_SHIFT_LEVEL, 12'($urandom_range(3, 5)));
    write_reg(REG_EDGE_THRESHOLD, 12'($urandom_range(0, 2047)));
    write_reg(REG_COLOR_MODE, 12'($urandom_range(0, 1)));
    for (i = 0; i < 400; i++)
      push_pixel(pix_t'($urandom_range(0, 255)), pix_t'($urandom_range(0, 255)),
                 pix_t'($urandom_range(0, 255)));
    drain_backlog();
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    rst_n          = 1'b0;
    tracker = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    run_wide_phase();
    while (fed_items < 1950) run_random_phase();
    settle();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_px.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // result side: random stalls plus one long hold-off to back the block up
  initial begin
    int unsigned gap, taken, left;
    bit          busy;
    out_ch.ready = 1'b0;
    taken = 0;
    left  = 0;
    busy  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (left == 0) begin
        busy = ($urandom_range(0, 3) != 0);
        left = $urandom_range(10, 60);
      end
      left--;
      gap = busy ? $urandom_range(0, 17) : 0;
      if (taken == 150) gap = 600;
      @(negedge clk);
      if (gap != 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      tracker.match_result(out_ch.payload);
      taken++;
    end
  end

  initial begin
    #(3_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
design/tls_pkg.sv
design/tls_stream_if.sv
design/tls_line_mem.sv
design/tls_chan.sv
design/threshold_laplacian_sharpen_unit.sv
bench/threshold_laplacian_sharpen_unit_test.sv
